/* hw/rtl/data_run_list_decoder_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the data run list decoder
// Each check reports through $error; the bodies are left empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef DATA_RUN_LIST_DECODER_CORE_MACROS_SVH
`define DATA_RUN_LIST_DECODER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is high.
`define DRLD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define DRLD_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define DRLD_ASSERT_IMP(label, clk, rst, ante, cons)
`define DRLD_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

/* hw/rtl/drld_pkg.sv */
// ----------------------------------------------------------------------------
// drld_pkg
// Result type, end reason codes and byte helpers for the run list decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package drld_pkg;

  localparam logic [1:0] REASON_ZERO_HDR  = 2'd0;
  localparam logic [1:0] REASON_BUF_END   = 2'd1;
  localparam logic [1:0] REASON_ZERO_LEN  = 2'd2;
  localparam logic [1:0] REASON_TRUNCATED = 2'd3;

  localparam int unsigned FieldBytes = 8;

  typedef struct packed {
    logic               run_present;
    logic               is_sparse;
    logic signed [63:0] cluster_start;
    logic        [63:0] run_length;
    logic               list_done;
    logic        [1:0]  end_reason;
  } result_t;

  function automatic result_t end_result(input logic [1:0] reason);
    result_t r;
    r.run_present   = 1'b0;
    r.is_sparse     = 1'b0;
    r.cluster_start = '0;
    r.run_length    = '0;
    r.list_done     = 1'b1;
    r.end_reason    = reason;
    return r;
  endfunction

  function automatic result_t run_result(input logic sparse, input logic [63:0] cluster,
                                         input logic [63:0] len);
    result_t r;
    r.run_present   = 1'b1;
    r.is_sparse     = sparse;
    r.cluster_start = cluster;
    r.run_length    = len;
    r.list_done     = 1'b0;
    r.end_reason    = REASON_ZERO_HDR;
    return r;
  endfunction

  // Drop a byte into its little-endian lane; lanes past the eighth are ignored.
  function automatic logic [63:0] put_byte(input logic [63:0] acc, input logic [7:0] b,
                                           input logic [3:0] idx);
    logic [63:0] r;
    r = acc;
    for (int k = 0; k < FieldBytes; k++) begin
      if (!idx[3] && (idx[2:0] == 3'(k))) begin
        r[8*k +: 8] = b;
      end
    end
    return r;
  endfunction

  // Sign-extend from nbytes bytes; eight or more bytes stand as they are.
  function automatic logic [63:0] sign_ext(input logic [63:0] val, input logic [3:0] nbytes);
    logic [63:0] r;
    logic [5:0]  sbit;
    logic        sgn;
    r    = val;
    sbit = 6'({nbytes[2:0], 3'b000} - 6'd1);
    sgn  = val[sbit];
    if (!nbytes[3]) begin
      for (int k = 0; k < FieldBytes; k++) begin
        if (4'(k) >= nbytes) begin
          r[8*k +: 8] = {8{sgn}};
        end
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/data_run_list_decoder_core.sv */
// Each byte's result is loaded into the output register when the byte is transferred.
// Throughput: one byte per cycle while data_stall is low; the single add-and-extend path per byte sets it.
// A byte that yields a run plus a clean buffer end holds the input while the
// run waits in the output register with the clean end result queued behind it.
// Reset (rst, synchronous, active high): header wait, cluster sum zero, no result.
`timescale 1ns / 1ps
`default_nettype none
`include "data_run_list_decoder_core_macros.svh"

// ----------------------------------------------------------------------------
// data_run_list_decoder_core
// Decodes a byte stream of run list entries into run length / start cluster
// results, with one end-marked result per list.
// ----------------------------------------------------------------------------
module data_run_list_decoder_core (
  input  wire logic               clk,
  input  wire logic               rst,
  // byte channel
  input  wire logic               data_valid,
  output logic                    data_stall,
  input  wire logic [7:0]         data_byte,
  input  wire logic               list_start,
  input  wire logic               buffer_end,
  // result channel
  output logic                    result_valid,
  input  wire logic               result_stall,
  output logic                    run_present,
  output logic                    is_sparse,
  output logic signed [63:0]      cluster_start,
  output logic        [63:0]      run_length,
  output logic                    list_done,
  output logic        [1:0]       end_reason
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_OFFSET,
    PH_ENDED
  } phase_t;

  // Decode state
  phase_t      phase;
  logic [3:0]  length_bytes;
  logic [3:0]  offset_len;
  logic [3:0]  byte_index;
  logic [63:0] length_accum;
  logic [63:0] offset_accum;
  logic [63:0] cluster_sum;

  // Output register plus a pending clean-end result
  drld_pkg::result_t res;
  logic              pend_end;

  phase_t      phase_next;
  logic [3:0]  length_bytes_next;
  logic [3:0]  offset_len_next;
  logic [3:0]  byte_index_next;
  logic [63:0] length_accum_next;
  logic [63:0] offset_accum_next;
  logic [63:0] cluster_sum_next;

  logic              emit;
  logic              emit_two;
  drld_pkg::result_t emit_res;

  phase_t      phase_cur;
  logic [63:0] cluster_cur;
  logic [3:0]  byte_inc;
  logic [63:0] len_new;
  logic [63:0] off_new;
  logic [63:0] off_ext;
  logic        take;

  // Take a byte only when the output slot is free, or drains this cycle with
  // nothing queued behind it.
  assign data_stall = result_valid && (result_stall || pend_end);
  assign take       = data_valid && !data_stall;

  // list_start restarts the list before the byte is used.
  assign phase_cur   = list_start ? PH_HEADER : phase;
  assign cluster_cur = list_start ? 64'd0 : cluster_sum;
  assign byte_inc    = byte_index + 4'd1;
  assign len_new     = drld_pkg::put_byte(length_accum, data_byte, byte_index);
  assign off_new     = drld_pkg::put_byte(offset_accum, data_byte, byte_index);
  assign off_ext     = drld_pkg::sign_ext(off_new, offset_len);

  always_comb begin
    phase_next        = phase_cur;
    length_bytes_next = length_bytes;
    offset_len_next   = offset_len;
    byte_index_next   = byte_index;
    length_accum_next = length_accum;
    offset_accum_next = offset_accum;
    cluster_sum_next  = cluster_cur;
    emit              = 1'b0;
    emit_two          = 1'b0;
    emit_res          = drld_pkg::end_result(drld_pkg::REASON_ZERO_HDR);

    case (phase_cur)
      PH_HEADER: begin
        length_bytes_next = data_byte[3:0];
        offset_len_next   = data_byte[7:4];
        if (data_byte == 8'd0) begin
          // zero header terminates the list, even on the last buffer byte
          emit       = 1'b1;
          emit_res   = drld_pkg::end_result(drld_pkg::REASON_ZERO_HDR);
          phase_next = PH_ENDED;
        end else if (data_byte[3:0] == 4'd0) begin
          emit       = 1'b1;
          emit_res   = drld_pkg::end_result(drld_pkg::REASON_ZERO_LEN);
          phase_next = PH_ENDED;
        end else if (buffer_end) begin
          emit       = 1'b1;
          emit_res   = drld_pkg::end_result(drld_pkg::REASON_TRUNCATED);
          phase_next = PH_ENDED;
        end else begin
          byte_index_next   = 4'd0;
          length_accum_next = 64'd0;
          offset_accum_next = 64'd0;
          phase_next        = PH_LENGTH;
        end
      end

      PH_LENGTH: begin
        length_accum_next = len_new;
        byte_index_next   = byte_inc;
        if (byte_inc < length_bytes || offset_len != 4'd0) begin
          if (buffer_end) begin
            // run cut short by the buffer end: drop it
            emit       = 1'b1;
            emit_res   = drld_pkg::end_result(drld_pkg::REASON_TRUNCATED);
            phase_next = PH_ENDED;
          end else if (byte_inc >= length_bytes) begin
            byte_index_next = 4'd0;
            phase_next      = PH_OFFSET;
          end
        end else begin
          // sparse run: no offset field, sum holds
          emit       = 1'b1;
          emit_res   = drld_pkg::run_result(1'b1, '1, len_new);
          emit_two   = buffer_end;
          phase_next = buffer_end ? PH_ENDED : PH_HEADER;
        end
      end

      PH_OFFSET: begin
        offset_accum_next = off_new;
        byte_index_next   = byte_inc;
        if (byte_inc < offset_len) begin
          if (buffer_end) begin
            emit       = 1'b1;
            emit_res   = drld_pkg::end_result(drld_pkg::REASON_TRUNCATED);
            phase_next = PH_ENDED;
          end
        end else begin
          offset_accum_next = off_ext;
          cluster_sum_next  = cluster_cur + off_ext;
          emit              = 1'b1;
          emit_res          = drld_pkg::run_result(1'b0, cluster_cur + off_ext, length_accum);
          emit_two          = buffer_end;
          phase_next        = buffer_end ? PH_ENDED : PH_HEADER;
        end
      end

      PH_ENDED: begin
        // drop bytes until the next list_start
      end

      default: begin
        phase_next = PH_HEADER;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      length_bytes <= 4'd0;
      offset_len   <= 4'd0;
      byte_index   <= 4'd0;
      length_accum <= 64'd0;
      offset_accum <= 64'd0;
      cluster_sum  <= 64'd0;
      result_valid <= 1'b0;
      pend_end     <= 1'b0;
      res          <= drld_pkg::end_result(drld_pkg::REASON_ZERO_HDR);
    end else if (take) begin
      // advance the decoder and load the result register
      phase        <= phase_next;
      length_bytes <= length_bytes_next;
      offset_len   <= offset_len_next;
      byte_index   <= byte_index_next;
      length_accum <= length_accum_next;
      offset_accum <= offset_accum_next;
      cluster_sum  <= cluster_sum_next;
      result_valid <= emit;
      pend_end     <= emit_two;
      res          <= emit_res;
    end else if (result_valid && !result_stall) begin
      // result transferred: follow with the queued clean end, or go empty
      if (pend_end) begin
        res      <= drld_pkg::end_result(drld_pkg::REASON_BUF_END);
        pend_end <= 1'b0;
      end else begin
        result_valid <= 1'b0;
      end
    end
  end

  assign run_present   = res.run_present;
  assign is_sparse     = res.is_sparse;
  assign cluster_start = res.cluster_start;
  assign run_length    = res.run_length;
  assign list_done     = res.list_done;
  assign end_reason    = res.end_reason;

  // A queued clean end only ever waits behind a shown run.
  `DRLD_ASSERT_IMP(a_pend_behind_run, clk, rst, pend_end, result_valid && run_present)
  // After a run with a queued end transfers, the clean end result follows.
  `DRLD_ASSERT_NXT(a_pend_follows, clk, rst, pend_end && !result_stall,
                   result_valid && list_done && end_reason == drld_pkg::REASON_BUF_END)
  // End results carry no run.
  `DRLD_ASSERT_IMP(a_end_no_run, clk, rst, result_valid && list_done, !run_present && !is_sparse)
  // Sparse runs report cluster -1.
  `DRLD_ASSERT_IMP(a_sparse_cluster, clk, rst, result_valid && is_sparse, cluster_start == '1)
  // An empty output slot never holds off the byte channel.
  `DRLD_ASSERT_IMP(a_no_idle_stall, clk, rst, !result_valid, !data_stall)

endmodule

`default_nettype wire
